FILE: hw/rtl/bil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_pkg
// Shared types and codes for the bounded indexed list.
// ----------------------------------------------------------------------------
package bil_pkg;

  localparam int MAX_IDX_W = 8;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_APPEND   = 3'd1,
    ACT_REMOVE   = 3'd2,
    ACT_POP      = 3'd3,
    ACT_READ     = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic                 rd;
    logic [MAX_IDX_W-1:0] pos;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/bounded_indexed_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_indexed_list
// Fixed-capacity ordered list of data words built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item (action, position, value) is taken at a rising edge with start
//   high and busy low. busy stays low, so an item may be issued every cycle.
//   Insert and append shift the slots above the position up by one, remove
//   and remove-last shift them down by one; every slot decides for itself
//   whether to hold, shift or load, so all slots move together.
//   The result (read_value, count, status) appears on the cycle after the
//   item is taken, marked by done for exactly one cycle. Throughput is one
//   beat per cycle. The receiver cannot hold results off.
//   Refused actions (full, out of range, empty) leave the list unchanged.
//   Reset empties the list (count zero, done low); slot contents are not
//   cleared and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_indexed_list #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [4:0]  position,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] read_value,
  output logic [4:0]  count,
  output logic [1:0]  status
);
  import bil_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 5) ? CW : 5;
  localparam logic [PW-1:0] CapW = PW'(CAPACITY);

  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [PW-1:0]         cnt_w;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         pos_eff;
  logic                  accept;
  act_t                  act;
  status_t               st_next;
  status_t               st_q;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] value_w;
  logic [DATA_WIDTH-1:0] rd_any;
  logic [DATA_WIDTH-1:0] rd_q;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign act    = act_t'(action);
  assign cnt_w  = PW'(cnt);
  assign pos_w  = PW'(position);

  generate
    if (DATA_WIDTH <= 32) begin : g_vin_narrow
      assign value_w = value[DATA_WIDTH-1:0];
    end else begin : g_vin_wide
      assign value_w = DATA_WIDTH'(value);
    end
  endgenerate

  // decode one item against the current fill
  always_comb begin
    st_next  = ST_OK;
    cnt_next = cnt;
    pos_eff  = pos_w;
    ctrl     = '0;
    case (act)
      ACT_INSERT, ACT_APPEND: begin
        if (act == ACT_APPEND) begin
          pos_eff = cnt_w;
        end
        if (cnt_w >= CapW) begin
          st_next = ST_FULL;
        end else if (pos_eff > cnt_w) begin
          st_next = ST_RANGE;
        end else begin
          ctrl.ins = accept;
          cnt_next = cnt + CW'(1);
        end
      end
      ACT_REMOVE, ACT_POP: begin
        if (act == ACT_POP) begin
          pos_eff = cnt_w - PW'(1);
        end
        if (cnt_w == '0) begin
          st_next = ST_EMPTY;
        end else if (pos_eff >= cnt_w) begin
          st_next = ST_RANGE;
        end else begin
          ctrl.del = accept;
          cnt_next = cnt - CW'(1);
        end
      end
      ACT_READ: begin
        if (pos_w < cnt_w) begin
          ctrl.rd = 1'b1;
        end else begin
          st_next = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    ctrl.pos = MAX_IDX_W'(pos_eff);
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_d;
      logic [DATA_WIDTH-1:0] upper_d;
      if (i == 0) begin : g_lo_end
        assign lower_d = value_w;
      end else begin : g_lo
        assign lower_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_hi_end
        assign upper_d = cell_data[i];
      end else begin : g_hi
        assign upper_d = cell_data[i+1];
      end
      bil_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .INDEX      (i)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_data   (value_w),
        .lower_data (lower_d),
        .upper_data (upper_d),
        .data       (cell_data[i]),
        .rd_data    (cell_rd[i])
      );
    end
  endgenerate

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_q <= st_next;
      rd_q <= rd_any;
    end
  end

  generate
    if (DATA_WIDTH >= 32) begin : g_vout_wide
      assign read_value = rd_q[31:0];
    end else begin : g_vout_narrow
      assign read_value = 32'(rd_q);
    end
  endgenerate

  assign count  = cnt_w[4:0];
  assign status = st_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_w <= CapW)
    else $error("fill count above capacity");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted beat without result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (cnt_w == CapW))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (cnt == '0))
    else $error("empty status on non-empty list");
`endif

endmodule

FILE: hw/rtl/bil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_cell
// One list slot: holds, shifts up from its lower neighbor, shifts down from
// its upper neighbor or loads the new word.
// ----------------------------------------------------------------------------
module bil_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                    clk,
  input  bil_pkg::cell_ctrl_t     ctrl,
  input  logic [DATA_WIDTH-1:0]   new_data,
  input  logic [DATA_WIDTH-1:0]   lower_data,
  input  logic [DATA_WIDTH-1:0]   upper_data,
  output logic [DATA_WIDTH-1:0]   data,
  output logic [DATA_WIDTH-1:0]   rd_data
);
  import bil_pkg::*;

  localparam logic [MAX_IDX_W-1:0] MyIdx = MAX_IDX_W'(INDEX);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (ctrl.pos == MyIdx);
  assign above_pos = (MyIdx > ctrl.pos);

  always_ff @(posedge clk) begin
    if (ctrl.ins && above_pos) begin
      data <= lower_data;
    end else if (ctrl.ins && at_pos) begin
      data <= new_data;
    end else if (ctrl.del && (above_pos || at_pos)) begin
      data <= upper_data;
    end
  end

  assign rd_data = (ctrl.rd && at_pos) ? data : '0;

endmodule
